/* rtl/core/clf_pkg.sv */
// ----------------------------------------------------------------------------
// clf_pkg
// Shared constants, types and controller/datapath interface structs for the
// command line framer.
// ----------------------------------------------------------------------------
package clf_pkg;

  // Longest command line that can be stored
  localparam int unsigned MAX_LEN = 32;

  // Store address and fill count widths
  localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_LEN + 1);

  // Result field widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LEN_W  = 6;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_START = 8'h23;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_PROMPT  = 2'd2,
    KIND_TOOLONG = 2'd3
  } kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic  cap;        // capture the incoming character
    logic  store;      // write the captured character into the line store
    logic  start_cmd;  // enter receiving with an empty line
    logic  end_cmd;    // return to waiting, clear the fill count
    logic  emit;       // load the output register
    kind_e emit_kind;  // kind of the loaded result
    logic  rd_first;   // rewind the read index
    logic  rd_issue;   // read the line store at the read index
    logic  rd_next;    // advance the read index
  } clf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic enable;
    logic receiving;
    logic is_start;
    logic is_eol;
    logic fill_zero;
    logic fill_full;
    logic rd_last;
    logic out_free;
  } clf_status_t;

endpackage

/* rtl/core/command_line_framer.sv */
// ----------------------------------------------------------------------------
// command_line_framer
// Frames command lines from a character stream: '#' opens a line, CR or LF
// closes it, and the stored line streams out byte by byte.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o   char_in_i
//   out      output     out_valid_o/out_stall_i kind_o, data_o, length_o, last_o
//   cfg      input      cfg_we_i                cfg_wdata_i (enable)
//
// Each character is captured, then decided on, before the next is taken.
// A completed line streams out byte by byte: each byte costs a read
// of the line store RAM and the output load of its registered read data.
// Reset clears enable, the line state and the output valid; no clearing pass.
// A stalled output holds the controller in its deciding or emitting state;
// a result waits in the output register while the next character is taken.
// ----------------------------------------------------------------------------
module command_line_framer
  import clf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CHAR_W-1:0] char_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [CHAR_W-1:0] data_o,
  output logic [LEN_W-1:0]  length_o,
  output logic              last_o
);

  clf_cmd_t    cmd;
  clf_status_t status;

  clf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  clf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .char_in_i   (char_in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

endmodule

/* rtl/core/clf_ram.sv */
// ----------------------------------------------------------------------------
// clf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/clf_datapath.sv */
// ----------------------------------------------------------------------------
// clf_datapath
// Character capture, enable and line state, line store and output register
// of the command line framer.
// ----------------------------------------------------------------------------
module clf_datapath
  import clf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [CHAR_W-1:0] char_in_i,
  input  clf_cmd_t          cmd_i,
  output clf_status_t       status_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [CHAR_W-1:0] data_o,
  output logic [LEN_W-1:0]  length_o,
  output logic              last_o
);

  logic [CHAR_W-1:0] char_q;
  logic              enable_q;
  logic              receiving_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [ADDR_W-1:0] rd_idx_q;
  logic [CHAR_W-1:0] ram_rdata;

  logic              out_valid_q;
  kind_e             kind_q, kind_d;
  logic [CHAR_W-1:0] data_q, data_d;
  logic [LEN_W-1:0]  length_q, length_d;
  logic              last_q, last_d;
  logic              rd_last;

  // Capture the character of the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      char_q <= char_in_i;
    end
  end

  // Line state: a config write aborts any partial line
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.start_cmd || cmd_i.end_cmd) begin
      fill_d = '0;
    end else if (cmd_i.store) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      receiving_q <= 1'b0;
      fill_q      <= '0;
    end else if (cfg_we_i) begin
      enable_q    <= cfg_wdata_i;
      receiving_q <= 1'b0;
      fill_q      <= '0;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.start_cmd) begin
        receiving_q <= 1'b1;
      end else if (cmd_i.end_cmd) begin
        receiving_q <= 1'b0;
      end
    end
  end

  // Read index for streaming the stored line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_first) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_q <= rd_idx_q + ADDR_W'(1);
    end
  end

  assign rd_last = ((FILL_W'(rd_idx_q) + FILL_W'(1)) == fill_q);

  // Line store
  clf_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (char_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Build the result payload
  always_comb begin
    kind_d   = cmd_i.emit_kind;
    data_d   = '0;
    length_d = '0;
    last_d   = 1'b1;
    if (cmd_i.emit_kind == KIND_BYTE) begin
      data_d   = ram_rdata;
      length_d = LEN_W'(fill_q);
      last_d   = rd_last;
    end
  end

  // Output register: drop valid once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q   <= kind_d;
      data_q   <= data_d;
      length_q <= length_d;
      last_q   <= last_d;
    end
  end

  // Status to the controller
  always_comb begin
    status_o.enable    = enable_q;
    status_o.receiving = receiving_q;
    status_o.is_start  = (char_q == CH_START);
    status_o.is_eol    = (char_q == CH_CR) || (char_q == CH_LF);
    status_o.fill_zero = (fill_q == '0);
    status_o.fill_full = (fill_q >= FILL_W'(MAX_LEN));
    status_o.rd_last   = rd_last;
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;
  assign length_o    = length_q;
  assign last_o      = last_q;

endmodule

/* rtl/core/clf_ctrl.sv */
// ----------------------------------------------------------------------------
// clf_ctrl
// Controller state machine of the command line framer: takes a character,
// decides on it, and sequences the streaming of a completed line.
// ----------------------------------------------------------------------------
module clf_ctrl
  import clf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  clf_status_t status_i,
  output clf_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IN   = 4'b0001,
    S_EVAL = 4'b0010,
    S_READ = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IN);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IN: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!status_i.enable) begin
          state_d = S_IN;
        end else if (!status_i.receiving) begin
          if (status_i.is_start) begin
            cmd_o.start_cmd = 1'b1;
            state_d         = S_IN;
          end else if (status_i.is_eol) begin
            // hold until the output register is free
            if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = KIND_PROMPT;
              state_d         = S_IN;
            end
          end else begin
            state_d = S_IN;
          end
        end else if (status_i.is_eol) begin
          if (status_i.fill_zero) begin
            if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = KIND_EMPTY;
              cmd_o.end_cmd   = 1'b1;
              state_d         = S_IN;
            end
          end else begin
            cmd_o.rd_first = 1'b1;
            state_d        = S_READ;
          end
        end else if (status_i.fill_full) begin
          if (status_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = KIND_TOOLONG;
            cmd_o.end_cmd   = 1'b1;
            state_d         = S_IN;
          end
        end else begin
          cmd_o.store = 1'b1;
          state_d     = S_IN;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        // emit one stored byte, then read the next or finish the line
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_BYTE;
          if (status_i.rd_last) begin
            cmd_o.end_cmd = 1'b1;
            state_d       = S_IN;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/clf_checker.sv */
// ----------------------------------------------------------------------------
// clf_checker
// Port-level checks of the command line framer, bound to the top level.
// ----------------------------------------------------------------------------
module clf_checker
  import clf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        kind_o,
  input logic [CHAR_W-1:0] data_o,
  input logic [LEN_W-1:0]  length_o,
  input logic              last_o
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(data_o)
      && $stable(length_o) && $stable(last_o))
    else $error("stalled result beat changed");

  // Non-byte results are single, closing beats with zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_BYTE) |-> last_o && (data_o == '0) && (length_o == '0))
    else $error("non-byte result with payload or without last");

  // A taken character stalls the input in the cycle after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on consecutive cycles");

  // Streamed bytes carry the nonzero length of their line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_BYTE) |-> (length_o != '0))
    else $error("byte beat with zero line length");

  // The input is not taken while a line is still streaming out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_BYTE) && !last_o |-> in_stall_o)
    else $error("input taken during line streaming");

endmodule

bind command_line_framer clf_checker u_clf_checker (.*);
